### hdl/aes128_block_encrypt_defines.svh
// ----------------------------------------------------------------------------
// AES-128 block encryption: assertion macros
// Shared assertion helpers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH
`ifndef SYNTHESIS
// Assert that an implication holds at every clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition holds in the cycle after another holds.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Types, constants and byte functions shared by the round cells.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] plaintext_high;
        logic [63:0] plaintext_low;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] ciphertext_high;
        logic [63:0] ciphertext_low;
    } t_out_beat;

    // Data carried from one round cell to the next.
    typedef struct packed {
        logic         valid;
        logic [127:0] state;
        logic [127:0] rkey;
    } t_cell_link;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    // Round constant for round 1 to 10.
    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
            4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
            4'd9: r = 8'h1b; 4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Source byte of the combined ShiftRows permutation.
    function automatic int perm(input int i);
        return (i + 4 * (i % 4)) % 16;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

### hdl/aes_round_cell.sv
// ----------------------------------------------------------------------------
// AES round cell
// One round of the cipher and one step of the key schedule, registered.
// ----------------------------------------------------------------------------
module aes_round_cell
    import aes_pkg::*;
#(
    parameter int ROUND = 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_link i_link,
    output t_cell_link o_link
);

    localparam logic [3:0] RND = 4'(ROUND);
    localparam bit LAST = (ROUND == NUM_ROUNDS);

    logic [7:0]   s_in  [16];
    logic [7:0]   s_sub [16];
    logic [7:0]   s_mix [16];
    logic [31:0]  w_in  [4];
    logic [31:0]  w_out [4];
    logic [31:0]  w_tmp;
    logic [127:0] n_state;
    logic [127:0] n_rkey;
    logic         r_valid;
    logic [127:0] r_state;
    logic [127:0] r_rkey;

    // Byte and word views; byte 0 is the most significant.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s_in[i] = i_link.state[127 - 8*i -: 8];
        end
        for (int i = 0; i < 4; i++) begin
            w_in[i] = i_link.rkey[127 - 32*i -: 32];
        end
    end

    // Key schedule step: rotate, substitute, round constant.
    always_comb begin
        w_tmp = {sbox(w_in[3][23:16]) ^ rcon(RND), sbox(w_in[3][15:8]),
                 sbox(w_in[3][7:0]), sbox(w_in[3][31:24])};
        w_out[0] = w_in[0] ^ w_tmp;
        w_out[1] = w_in[1] ^ w_out[0];
        w_out[2] = w_in[2] ^ w_out[1];
        w_out[3] = w_in[3] ^ w_out[2];
        n_rkey = {w_out[0], w_out[1], w_out[2], w_out[3]};
    end

    // SubBytes with ShiftRows, then MixColumns unless this is the last round.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s_sub[i] = sbox(s_in[perm(i)]);
        end
        for (int c = 0; c < 16; c += 4) begin
            s_mix[c]   = xtime(s_sub[c]) ^ xtime(s_sub[c+1]) ^ s_sub[c+1]
                       ^ s_sub[c+2] ^ s_sub[c+3];
            s_mix[c+1] = s_sub[c] ^ xtime(s_sub[c+1]) ^ xtime(s_sub[c+2])
                       ^ s_sub[c+2] ^ s_sub[c+3];
            s_mix[c+2] = s_sub[c] ^ s_sub[c+1] ^ xtime(s_sub[c+2])
                       ^ xtime(s_sub[c+3]) ^ s_sub[c+3];
            s_mix[c+3] = xtime(s_sub[c]) ^ s_sub[c] ^ s_sub[c+1]
                       ^ s_sub[c+2] ^ xtime(s_sub[c+3]);
        end
        for (int i = 0; i < 16; i++) begin
            n_state[127 - 8*i -: 8] = (LAST ? s_sub[i] : s_mix[i])
                                    ^ n_rkey[127 - 8*i -: 8];
        end
    end

    // Valid flag is control; state and key are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_rkey  <= n_rkey;
    end

    assign o_link = '{valid: r_valid, state: r_state, rkey: r_rkey};

endmodule

### hdl/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Pipelined AES-128 encryptor with one round cell per round.
// ----------------------------------------------------------------------------
// A block is taken in every cycle that i_start is high (o_busy is always low).
// Its ciphertext appears on o_result for one cycle, with o_done high, after
// passing the head register for the initial key addition and then each round
// cell of the ten-cell chain, which carries each block's own round key along
// with it. The result cannot be held off and must be taken as it appears.
// The user must write key registers through the write port only while no block
// is in flight; the block does not enforce this. Every block uses the key held when it was taken.
`include "aes128_block_encrypt_defines.svh"

module aes128_block_encrypt
    import aes_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in_beat              i_data,
    output logic                  o_done,
    output t_out_beat             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [63:0]  r_key_high;
    logic [63:0]  r_key_low;
    logic         accept;
    logic         r_head_valid;
    logic [127:0] r_head_state;
    logic [127:0] r_head_rkey;
    t_cell_link   link [NUM_ROUNDS+1];

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Head stage: initial key addition.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
        end else begin
            r_head_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_state <= {i_data.plaintext_high, i_data.plaintext_low}
                        ^ {r_key_high, r_key_low};
        r_head_rkey  <= {r_key_high, r_key_low};
    end

    assign link[0] = '{valid: r_head_valid, state: r_head_state, rkey: r_head_rkey};

    // Chain of round cells.
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_round_cell #(
            .ROUND(g + 1)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_link (link[g]),
            .o_link (link[g+1])
        );
    end

    assign o_done   = link[NUM_ROUNDS].valid;
    assign o_result = link[NUM_ROUNDS].state;

    // A taken block reaches the head in the next cycle.
    `AES_ASSERT_NEXT(a_head_follows, i_clk, i_rst_n, accept, r_head_valid)
    // The first cell passes the valid flag along without loss.
    `AES_ASSERT_NEXT(a_chain_moves, i_clk, i_rst_n, link[0].valid, link[1].valid)
    `AES_ASSERT_IMP(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy)

endmodule

### dv/aes128_block_encrypt_tb.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption testbench
// Drives plaintext beats under several keys and checks every ciphertext beat
// against an in-bench AES-128 model, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_block_encrypt_tb
    import aes_pkg::*;
();

    localparam int LATENCY   = 11;
    localparam int CYCLE_CAP = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    t_in_beat              data;
    logic                  done;
    t_out_beat             result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Plaintext beats waiting to be sent and ciphertexts awaited.
    t_in_beat  pending_blocks[$];
    t_out_beat cipher_due[$];
    logic [63:0] key_hi_mdl, key_lo_mdl;
    bit  hold_off;
    bit  no_idle;
    bit  failed;
    int  cycle_cnt;

    aes128_block_encrypt u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_data(data), .o_done(done), .o_result(result),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // S-box built once from the field inverse and the affine map.
    logic [7:0] sub_lut[256];

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    initial begin
        logic [7:0] inv, x;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h00;
            for (int u = 1; u < 256; u++)
                if (gf_mul(v[7:0], u[7:0]) == 8'h01) inv = u[7:0];
            x = inv;
            for (int k = 0; k < 8; k++)
                x[k] = inv[k] ^ inv[(k + 4) % 8] ^ inv[(k + 5) % 8]
                       ^ inv[(k + 6) % 8] ^ inv[(k + 7) % 8];
            sub_lut[v] = x ^ 8'h63;
        end
    end

    // Full AES-128 encryption of one block under the current model key.
    function automatic t_out_beat aes_encrypt(input t_in_beat blk);
        logic [7:0] rk[176];
        logic [7:0] st[16];
        logic [7:0] tmp[16];
        logic [7:0] w[4];
        logic [7:0] first, rc;
        logic [127:0] kv, sv, ov;
        t_out_beat res;
        kv = {key_hi_mdl, key_lo_mdl};
        sv = blk;
        for (int i = 0; i < 16; i++) begin
            rk[i] = kv[127 - 8 * i -: 8];
            st[i] = sv[127 - 8 * i -: 8] ^ rk[i];
        end
        rc = 8'h01;
        for (int k = 4; k < 44; k++) begin
            for (int j = 0; j < 4; j++) w[j] = rk[4 * (k - 1) + j];
            if (k % 4 == 0) begin
                first = w[0];
                w[0] = sub_lut[w[1]] ^ rc;
                w[1] = sub_lut[w[2]];
                w[2] = sub_lut[w[3]];
                w[3] = sub_lut[first];
                rc = gf_dbl(rc);
            end
            for (int j = 0; j < 4; j++) rk[4 * k + j] = rk[4 * (k - 4) + j] ^ w[j];
        end
        for (int r = 1; r <= 10; r++) begin
            // SubBytes with ShiftRows folded in.
            for (int i = 0; i < 16; i++) tmp[i] = sub_lut[st[(i + 4 * (i % 4)) % 16]];
            for (int c = 0; c < 16; c += 4) begin
                if (r < 10) begin
                    st[c]   = gf_dbl(tmp[c] ^ tmp[c+1]) ^ tmp[c+1] ^ tmp[c+2] ^ tmp[c+3];
                    st[c+1] = gf_dbl(tmp[c+1] ^ tmp[c+2]) ^ tmp[c] ^ tmp[c+2] ^ tmp[c+3];
                    st[c+2] = gf_dbl(tmp[c+2] ^ tmp[c+3]) ^ tmp[c] ^ tmp[c+1] ^ tmp[c+3];
                    st[c+3] = gf_dbl(tmp[c+3] ^ tmp[c]) ^ tmp[c] ^ tmp[c+1] ^ tmp[c+2];
                end else begin
                    for (int j = 0; j < 4; j++) st[c+j] = tmp[c+j];
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[16 * r + i];
        end
        for (int i = 0; i < 16; i++) ov[127 - 8 * i -: 8] = st[i];
        res = ov;
        return res;
    endfunction

    // Driver: offers the next pending beat unless held off, idling at random unless told not to.
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                cipher_due.push_back(aes_encrypt(data));
                void'(pending_blocks.pop_front());
            end
            if (pending_blocks.size() > 0 && !hold_off
                    && (no_idle || $urandom_range(99) >= 35)
                    && !(start && !busy && pending_blocks.size() == 0)) begin
                start <= 1'b1;
                data  <= pending_blocks[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every done beat is checked against the oldest expectation.
    always @(posedge clk) begin
        t_out_beat exp_ct;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && done) begin
            if (cipher_due.size() == 0) begin
                $error("ciphertext beat with none expected: %h", result);
                failed = 1'b1;
            end else begin
                exp_ct = cipher_due.pop_front();
                if (result.ciphertext_high !== exp_ct.ciphertext_high) begin
                    $error("ciphertext_high expected %h got %h",
                           exp_ct.ciphertext_high, result.ciphertext_high);
                    failed = 1'b1;
                end
                if (result.ciphertext_low !== exp_ct.ciphertext_low) begin
                    $error("ciphertext_low expected %h got %h",
                           exp_ct.ciphertext_low, result.ciphertext_low);
                    failed = 1'b1;
                end
            end
        end
        if (cycle_cnt > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_blocks.size() > 0 || start || cipher_due.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Key writes are only made with the pipeline empty; the write enable is lowered
    // after each write so that back-to-back writes never clash on the enable.
    task automatic write_key(input t_cfg_idx idx, input logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_KEY_HIGH) key_hi_mdl = val;
        else key_lo_mdl = val;
        @(posedge clk);
    endtask

    function automatic t_in_beat rand_block();
        t_in_beat b;
        b.plaintext_high = {$urandom, $urandom};
        b.plaintext_low  = {$urandom, $urandom};
        return b;
    endfunction

    task automatic queue_random(input int n);
        repeat (n) pending_blocks.push_back(rand_block());
    endtask

    initial begin
        t_in_beat b;
        rst_n = 1'b0; start = 1'b0; data = '0;
        cfg_we = 1'b0; cfg_idx = CFG_KEY_HIGH; cfg_data = '0;
        key_hi_mdl = '0; key_lo_mdl = '0;
        hold_off = 1'b0; no_idle = 1'b0; failed = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key of all zeros, with extreme blocks, the standard test block and a block with only its end bits set.
        pending_blocks.push_back('0);
        pending_blocks.push_back('1);
        b.plaintext_high = 64'h0011223344556677;
        b.plaintext_low  = 64'h8899aabbccddeeff;
        pending_blocks.push_back(b);
        pending_blocks.push_back({64'h8000000000000000, 64'h0000000000000001});
        wait_drained();

        // Standard key, then the all-ones key, each with a few directed blocks.
        write_key(CFG_KEY_HIGH, 64'h0001020304050607);
        write_key(CFG_KEY_LOW,  64'h08090a0b0c0d0e0f);
        pending_blocks.push_back(b);
        pending_blocks.push_back('0);
        pending_blocks.push_back('1);
        wait_drained();
        write_key(CFG_KEY_HIGH, '1);
        write_key(CFG_KEY_LOW,  '1);
        pending_blocks.push_back('0);
        pending_blocks.push_back('1);
        pending_blocks.push_back({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
        wait_drained();
        // Key changed between blocks: only the high half moves.
        write_key(CFG_KEY_HIGH, '0);
        pending_blocks.push_back('1);
        pending_blocks.push_back(b);
        wait_drained();

        // Random blocks under a series of random keys, part with no idling.
        for (int phase = 0; phase < 8; phase++) begin
            write_key(CFG_KEY_HIGH, {$urandom, $urandom});
            write_key(CFG_KEY_LOW,  {$urandom, $urandom});
            no_idle = (phase == 3);
            queue_random(50);
            // Sender holds off until the pipeline has emptied.
            if (phase == 5) begin
                wait (cipher_due.size() > 0);
                hold_off = 1'b1;
                while (start || cipher_due.size() > 0) @(posedge clk);
                hold_off = 1'b0;
            end
            queue_random(50);
            wait_drained();
        end
        no_idle = 1'b0;

        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
